/* sv/mbpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mbpc_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MANUFACTURER_ENABLE = 3'd0,
    REG_TOUCH_ENABLE        = 3'd1,
    REG_MODE_LAST           = 3'd2,
    REG_BOOT_HOLD_MS        = 3'd3,
    REG_SHORT_LIMIT_MS      = 3'd4,
    REG_LONG_LIMIT_MS       = 3'd5,
    REG_SUPERLONG_LIMIT_MS  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PRESS_NONE      = 3'd0,
    PRESS_SHORT     = 3'd1,
    PRESS_LONG      = 3'd2,
    PRESS_SUPERLONG = 3'd3,
    PRESS_LONGEST   = 3'd4
  } press_class_t;

  localparam logic [3:0]  ModeLastReset      = 4'd5;
  localparam logic [15:0] BootHoldReset      = 16'd3000;
  localparam logic [15:0] ShortLimitReset    = 16'd1000;
  localparam logic [15:0] LongLimitReset     = 16'd3000;
  localparam logic [15:0] SuperlongLimitReset = 16'd7000;

  typedef struct packed {
    logic        manufacturer_enable;
    logic        touch_enable;
    logic [3:0]  mode_last;
    logic [15:0] boot_hold_ms;
    logic [15:0] short_limit_ms;
    logic [15:0] long_limit_ms;
    logic [15:0] superlong_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        mode_level;
    logic        block_level;
    logic        reset_level;
    logic        touch_level;
  } item_t;

  typedef struct packed {
    logic [3:0]   display_mode;
    logic         display_block;
    logic         uptime_shown;
    logic         save_request;
    logic         clear_request;
    logic [3:0]   clear_mode;
    logic         clear_block;
    press_class_t press_class;
  } result_t;

  // Next mode with wrap past the configured last mode.
  function automatic logic [3:0] mode_advance(input logic [3:0] mode,
                                              input logic [3:0] last);
    logic [4:0] m;
    m = {1'b0, mode} + 5'd1;
    if (m > {1'b0, last}) begin
      return 4'd0;
    end
    return m[3:0];
  endfunction

endpackage
`default_nettype wire

/* sv/mbpc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module mbpc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [mbpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [mbpc_pkg::CfgDataW-1:0]   cfg_data,
  output mbpc_pkg::cfg_t                       cfg
);
  import mbpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manufacturer_enable <= 1'b0;
      cfg.touch_enable        <= 1'b0;
      cfg.mode_last           <= ModeLastReset;
      cfg.boot_hold_ms        <= BootHoldReset;
      cfg.short_limit_ms      <= ShortLimitReset;
      cfg.long_limit_ms       <= LongLimitReset;
      cfg.superlong_limit_ms  <= SuperlongLimitReset;
    end else if (cfg_write) begin
      // Indexes past the list are dropped.
      case (cfg_index)
        REG_MANUFACTURER_ENABLE: cfg.manufacturer_enable <= cfg_data[0];
        REG_TOUCH_ENABLE:        cfg.touch_enable        <= cfg_data[0];
        REG_MODE_LAST:           cfg.mode_last           <= cfg_data[3:0];
        REG_BOOT_HOLD_MS:        cfg.boot_hold_ms        <= cfg_data;
        REG_SHORT_LIMIT_MS:      cfg.short_limit_ms      <= cfg_data;
        REG_LONG_LIMIT_MS:       cfg.long_limit_ms       <= cfg_data;
        REG_SUPERLONG_LIMIT_MS:  cfg.superlong_limit_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/mbpc_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module mbpc_step (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire mbpc_pkg::item_t item,
  input  wire mbpc_pkg::cfg_t  cfg,
  output mbpc_pkg::result_t res
);
  import mbpc_pkg::*;

  logic        last_mode_level, last_reset_level, last_touch_level;
  logic        touch_held, touch_held_next;
  logic [31:0] press_start, press_start_next;
  logic [3:0]  mode_now, mode_now_next;
  logic        block_now, block_now_next;
  logic        uptime_on, uptime_on_next;

  logic        touch_lv, active, buttons;
  logic        mode_fall, reset_fall, touch_rise, release_hit;
  logic        held_mid;
  logic [31:0] start_mid, dur;
  logic [3:0]  mode_mid;
  logic        block_mid, clr_mid;
  logic        is_short, is_long, is_superlong;

  assign touch_lv   = cfg.touch_enable & item.touch_level;
  assign active     = item.now_ms >= {16'd0, cfg.boot_hold_ms};
  assign buttons    = active & cfg.manufacturer_enable;
  assign mode_fall  = buttons & ~item.mode_level & last_mode_level;
  assign reset_fall = buttons & ~item.reset_level & last_reset_level;
  assign touch_rise = active & touch_lv & ~last_touch_level;

  // Wired buttons first: mode, then block switch, then reset.
  assign mode_mid  = mode_fall ? mode_advance(mode_now, cfg.mode_last) : mode_now;
  assign block_mid = buttons ? item.block_level : block_now;
  assign clr_mid   = reset_fall;

  assign held_mid    = touch_rise | touch_held;
  assign start_mid   = touch_rise ? item.now_ms : press_start;
  assign release_hit = active & ~touch_lv & held_mid;
  assign dur         = item.now_ms - start_mid;

  assign is_short     = dur < {16'd0, cfg.short_limit_ms};
  assign is_long      = dur < {16'd0, cfg.long_limit_ms};
  assign is_superlong = dur < {16'd0, cfg.superlong_limit_ms};

  always_comb begin
    mode_now_next     = mode_mid;
    block_now_next    = block_mid;
    uptime_on_next    = uptime_on;
    touch_held_next   = release_hit ? 1'b0 : held_mid;
    press_start_next  = start_mid;
    res.save_request  = mode_fall;
    res.clear_request = clr_mid;
    res.clear_mode    = clr_mid ? mode_mid : 4'd0;
    res.clear_block   = clr_mid & block_mid;
    res.press_class   = PRESS_NONE;
    if (release_hit) begin
      priority if (is_short) begin
        res.press_class  = PRESS_SHORT;
        mode_now_next    = mode_advance(mode_mid, cfg.mode_last);
        res.save_request = 1'b1;
      end else if (is_long) begin
        res.press_class = PRESS_LONG;
        block_now_next  = ~block_mid;
      end else if (is_superlong) begin
        res.press_class = PRESS_SUPERLONG;
        // A clear from the reset button already stands; keep one request.
        if (!clr_mid) begin
          res.clear_request = 1'b1;
          res.clear_mode    = mode_mid;
          res.clear_block   = block_mid;
        end
      end else begin
        res.press_class = PRESS_LONGEST;
        uptime_on_next  = ~uptime_on;
      end
    end
    res.display_mode  = mode_now_next;
    res.display_block = block_now_next;
    res.uptime_shown  = uptime_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode_level  <= 1'b0;
      last_reset_level <= 1'b0;
      last_touch_level <= 1'b0;
      touch_held       <= 1'b0;
      press_start      <= 32'd0;
      mode_now         <= 4'd0;
      block_now        <= 1'b0;
      uptime_on        <= 1'b0;
    end else if (step) begin
      last_mode_level  <= item.mode_level;
      last_reset_level <= item.reset_level;
      last_touch_level <= touch_lv;
      touch_held       <= touch_held_next;
      press_start      <= press_start_next;
      mode_now         <= mode_now_next;
      block_now        <= block_now_next;
      uptime_on        <= uptime_on_next;
    end
  end

endmodule
`default_nettype wire

/* sv/multifunction_button_press_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// Button and touch press controller. Each input beat is one sample (timestamp
// plus four levels) and yields exactly one result beat. A sample is captured
// in an input register, evaluated against the button/touch state and written
// to an output register, so one sample per clock is sustained while out_ready
// holds; the state update loop (edge detect, mode wrap, 32-bit hold compare)
// sets that rate. While a result waits on out_ready the input register can
// still take one sample; after that in_ready drops until the result is taken.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// and must only change while no sample is in flight.
module multifunction_button_press_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [31:0]                   now_ms,
  input  wire logic                          mode_level,
  input  wire logic                          block_level,
  input  wire logic                          reset_level,
  input  wire logic                          touch_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         display_mode,
  output logic                               display_block,
  output logic                               uptime_shown,
  output logic                               save_request,
  output logic                               clear_request,
  output logic [3:0]                         clear_mode,
  output logic                               clear_block,
  output logic [2:0]                         press_class,
  input  wire logic                          cfg_write,
  input  wire logic [mbpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mbpc_pkg::CfgDataW-1:0] cfg_data
);
  import mbpc_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t step_res;
  result_t out_res;

  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{now_ms: now_ms, mode_level: mode_level, block_level: block_level,
                   reset_level: reset_level, touch_level: touch_level};
    end
  end

  mbpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbpc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign display_mode  = out_res.display_mode;
  assign display_block = out_res.display_block;
  assign uptime_shown  = out_res.uptime_shown;
  assign save_request  = out_res.save_request;
  assign clear_request = out_res.clear_request;
  assign clear_mode    = out_res.clear_mode;
  assign clear_block   = out_res.clear_block;
  assign press_class   = out_res.press_class;

endmodule
`default_nettype wire

/* sv/mbpc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mbpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       save_request,
  input wire logic       clear_request,
  input wire logic [3:0] clear_mode,
  input wire logic       clear_block,
  input wire logic [2:0] press_class
);
  import mbpc_pkg::*;

  // A result beat holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before out_ready");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_class <= PRESS_LONGEST)
    else $error("press class out of range");

  a_clear_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !clear_request |-> clear_mode == 4'd0 && !clear_block)
    else $error("clear fields set without clear request");

  // A short touch always advances the mode and asks for a save.
  a_short_saves: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_class == PRESS_SHORT |-> save_request)
    else $error("short press without save request");

endmodule

bind multifunction_button_press_controller mbpc_checker u_mbpc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .save_request  (save_request),
  .clear_request (clear_request),
  .clear_mode    (clear_mode),
  .clear_block   (clear_block),
  .press_class   (press_class)
);
`default_nettype wire

/* bench/tb_multifunction_button_press_controller.sv */
`timescale 1ns / 1ps
module tb_multifunction_button_press_controller;
  import mbpc_pkg::*;

  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] now_ms = '0;
  logic        mode_level = 1'b0;
  logic        block_level = 1'b0;
  logic        reset_level = 1'b0;
  logic        touch_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  display_mode;
  logic        display_block;
  logic        uptime_shown;
  logic        save_request;
  logic        clear_request;
  logic [3:0]  clear_mode;
  logic        clear_block;
  logic [2:0]  press_class;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  multifunction_button_press_controller i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .now_ms(now_ms), .mode_level(mode_level), .block_level(block_level),
    .reset_level(reset_level), .touch_level(touch_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .display_mode(display_mode), .display_block(display_block),
    .uptime_shown(uptime_shown), .save_request(save_request),
    .clear_request(clear_request), .clear_mode(clear_mode),
    .clear_block(clear_block), .press_class(press_class),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Register shadow and predicted controller state.
  cfg_t        cfg_now = '{manufacturer_enable: 1'b0, touch_enable: 1'b0,
                           mode_last: ModeLastReset, boot_hold_ms: BootHoldReset,
                           short_limit_ms: ShortLimitReset,
                           long_limit_ms: LongLimitReset,
                           superlong_limit_ms: SuperlongLimitReset};
  logic        prev_mode_lv = 1'b0;
  logic        prev_reset_lv = 1'b0;
  logic        prev_touch_lv = 1'b0;
  logic        touch_down = 1'b0;
  logic [31:0] touch_t0 = '0;
  logic [3:0]  cur_mode = '0;
  logic        cur_block = 1'b0;
  logic        uptime_flag = 1'b0;

  result_t     pending_outputs[$];
  int          fail_count = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          settings_used = 0;
  int          class_seen[5] = '{default: 0};
  int          stall_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_cycles = 0;
  logic [31:0] stamp = '0;

  function automatic logic [3:0] step_mode(input logic [3:0] m);
    logic [4:0] n;
    n = {1'b0, m} + 5'd1;
    return (n > {1'b0, cfg_now.mode_last}) ? 4'd0 : n[3:0];
  endfunction

  // Advance the predicted state by one sample and return its outputs.
  function automatic result_t next_outputs(input item_t s);
    result_t     r;
    logic        touch;
    logic [31:0] held;
    touch = cfg_now.touch_enable ? s.touch_level : 1'b0;
    r = '0;
    r.press_class = PRESS_NONE;
    if (s.now_ms >= {16'd0, cfg_now.boot_hold_ms}) begin
      if (cfg_now.manufacturer_enable) begin
        if (!s.mode_level && prev_mode_lv) begin
          cur_mode = step_mode(cur_mode);
          r.save_request = 1'b1;
        end
        cur_block = s.block_level;
        if (!s.reset_level && prev_reset_lv) begin
          r.clear_request = 1'b1;
          r.clear_mode = cur_mode;
          r.clear_block = cur_block;
        end
      end
      if (touch && !prev_touch_lv) begin
        touch_down = 1'b1;
        touch_t0 = s.now_ms;
      end
      if (!touch && touch_down) begin
        held = s.now_ms - touch_t0;
        touch_down = 1'b0;
        if (held < {16'd0, cfg_now.short_limit_ms}) begin
          r.press_class = PRESS_SHORT;
          cur_mode = step_mode(cur_mode);
          r.save_request = 1'b1;
        end else if (held < {16'd0, cfg_now.long_limit_ms}) begin
          r.press_class = PRESS_LONG;
          cur_block = ~cur_block;
        end else if (held < {16'd0, cfg_now.superlong_limit_ms}) begin
          r.press_class = PRESS_SUPERLONG;
          // a reset-button clear in the same sample wins
          if (!r.clear_request) begin
            r.clear_request = 1'b1;
            r.clear_mode = cur_mode;
            r.clear_block = cur_block;
          end
        end else begin
          r.press_class = PRESS_LONGEST;
          uptime_flag = ~uptime_flag;
        end
      end
    end
    prev_mode_lv = s.mode_level;
    prev_reset_lv = s.reset_level;
    prev_touch_lv = touch;
    r.display_mode = cur_mode;
    r.display_block = cur_block;
    r.uptime_shown = uptime_flag;
    class_seen[r.press_class]++;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Both handshakes are sampled mid-cycle; the next rising edge takes the beat.
  always @(negedge clk) begin : handshake_monitor
    item_t   sample;
    result_t want;
    if (in_valid && in_ready) begin
      sample = '{now_ms, mode_level, block_level, reset_level, touch_level};
      pending_outputs.push_back(next_outputs(sample));
    end
    if (out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result beat with no sample pending");
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("display_mode", want.display_mode, display_mode);
        check_field("display_block", want.display_block, display_block);
        check_field("uptime_shown", want.uptime_shown, uptime_shown);
        check_field("save_request", want.save_request, save_request);
        check_field("clear_request", want.clear_request, clear_request);
        check_field("clear_mode", want.clear_mode, clear_mode);
        check_field("clear_block", want.clear_block, clear_block);
        check_field("press_class", want.press_class, press_class);
        results_checked++;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial forever begin
    @(posedge clk);
    if (rx_hold_cycles > 0) begin
      out_ready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic bit rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_sample(input logic [31:0] t, input logic m, input logic b,
                             input logic r, input logic tc);
    int gap;
    bit taken;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    mode_level <= m;
    block_level <= b;
    reset_level <= r;
    touch_level <= tc;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    samples_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(REG_MANUFACTURER_ENABLE, {15'd0, c.manufacturer_enable});
    write_reg(REG_TOUCH_ENABLE, {15'd0, c.touch_enable});
    write_reg(REG_MODE_LAST, {12'd0, c.mode_last});
    write_reg(REG_BOOT_HOLD_MS, c.boot_hold_ms);
    write_reg(REG_SHORT_LIMIT_MS, c.short_limit_ms);
    write_reg(REG_LONG_LIMIT_MS, c.long_limit_ms);
    write_reg(REG_SUPERLONG_LIMIT_MS, c.superlong_limit_ms);
    cfg_write <= 1'b0;
    cfg_now = c;
    settings_used++;
  endtask

  function automatic cfg_t make_cfg(input logic man, input logic tch,
                                    input logic [3:0] last, input logic [15:0] boot,
                                    input logic [15:0] s, input logic [15:0] l,
                                    input logic [15:0] sl);
    cfg_t c;
    c = '{manufacturer_enable: man, touch_enable: tch, mode_last: last,
          boot_hold_ms: boot, short_limit_ms: s, long_limit_ms: l,
          superlong_limit_ms: sl};
    return c;
  endfunction

  // Hold time near one of the class limits, or anywhere at all.
  function automatic logic [31:0] pick_hold_ms();
    logic [31:0] lim;
    int          off;
    off = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 5))
      0: lim = {16'd0, cfg_now.short_limit_ms};
      1: lim = {16'd0, cfg_now.long_limit_ms};
      2: lim = {16'd0, cfg_now.superlong_limit_ms};
      3: return $urandom_range(0, 65535);
      4: return $urandom_range(0, 200);
      default: return $urandom();
    endcase
    return lim + off;
  endfunction

  task automatic touch_press();
    logic [31:0] start;
    logic [31:0] hold;
    int          mids;
    start = stamp;
    hold = pick_hold_ms();
    mids = $urandom_range(0, 2);
    send_sample(start, rbit(), rbit(), rbit(), 1'b1);
    for (int k = 0; k < mids; k++) begin
      send_sample(start + (hold >> (mids - k)), rbit(), rbit(), rbit(), 1'b1);
    end
    stamp = start + hold;
    send_sample(stamp, rbit(), rbit(), rbit(), 1'b0);
    stamp += $urandom_range(1, 50);
  endtask

  // Press, a sample that steps back in time, then release at an arbitrary time.
  task automatic broken_press();
    send_sample(stamp, rbit(), rbit(), rbit(), 1'b1);
    send_sample(stamp - $urandom_range(0, 500), rbit(), rbit(), rbit(), rbit());
    send_sample($urandom(), rbit(), rbit(), rbit(), 1'b0);
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    int kind;
    stop_at = samples_sent + n;
    while (samples_sent < stop_at) begin
      if (stamp < {16'd0, cfg_now.boot_hold_ms}) begin
        stamp = cfg_now.boot_hold_ms + $urandom_range(0, 100);
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        touch_press();
      end else if (kind < 80) begin
        stamp += $urandom_range(0, 300);
        send_sample(stamp, rbit(), rbit(), rbit(), $urandom_range(0, 9) == 0);
      end else if (kind < 92) begin
        send_sample($urandom(), rbit(), rbit(), rbit(), rbit());
      end else begin
        broken_press();
      end
    end
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // Power-up settings: wired buttons and touch both off, levels only recorded.
  task automatic test_reset_state();
    set_idling(31, 52);
    for (int k = 0; k < 6; k++) begin
      send_sample(32'(k * 1500), rbit(), rbit(), rbit(), rbit());
    end
    wait_idle();
  endtask

  task automatic test_directed();
    program_cfg(make_cfg(1'b1, 1'b1, 4'd2, 16'd3000, 16'd1000, 16'd3000, 16'd7000));
    send_sample(32'd0, 1, 1, 1, 1);
    send_sample(32'd2999, 0, 0, 0, 1);        // edges inside boot hold
    send_sample(32'd3000, 1, 0, 1, 0);        // boot hold just over
    send_sample(32'd3001, 0, 1, 1, 0);        // mode advance, block follows
    send_sample(32'd3002, 1, 1, 1, 0);
    send_sample(32'd3003, 0, 1, 0, 0);        // advance then clear
    send_sample(32'd3004, 1, 1, 1, 1);
    send_sample(32'd4003, 0, 1, 1, 0);        // two advances, wrap
    send_sample(32'd4004, 1, 0, 1, 1);
    send_sample(32'd5004, 1, 0, 1, 0);        // long on the limit
    send_sample(32'd5005, 1, 0, 1, 1);
    send_sample(32'd8005, 1, 0, 0, 0);        // superlong plus reset: one clear
    send_sample(32'd9000, 1, 1, 1, 1);
    send_sample(32'd15999, 1, 1, 1, 0);       // just under superlong limit
    send_sample(32'd16000, 1, 1, 1, 1);
    send_sample(32'd23000, 1, 1, 1, 0);       // equal to limit: longest
    send_sample(32'hFFFF_FF00, 1, 1, 1, 1);
    send_sample(32'h0000_0100, 1, 1, 1, 0);   // wrapped into boot hold, keep holding
    send_sample(32'h0000_1000, 1, 1, 1, 0);   // release across the wrap
    send_sample(32'hFFFF_FFFF, 0, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    cfg_t sweep[7];
    sweep[0] = make_cfg(1'b1, 1'b1, 4'd15, 16'd0, 16'd0, 16'd0, 16'd0);
    sweep[1] = make_cfg(1'b1, 1'b1, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    sweep[2] = make_cfg(1'b1, 1'b1, 4'd5, 16'd3000, 16'd1000, 16'd3000, 16'd7000);
    sweep[3] = make_cfg(1'b0, 1'b1, 4'd7, 16'd500, 16'd200, 16'd400, 16'd800);
    sweep[4] = make_cfg(1'b1, 1'b0, 4'd3, 16'd100, 16'd300, 16'd600, 16'd900);
    // mode_last of zero and limits out of order
    sweep[5] = make_cfg(1'b1, 1'b1, 4'd0, 16'd50, 16'd900, 16'd300, 16'd600);
    sweep[6] = make_cfg(rbit(), rbit(), 4'($urandom_range(1, 15)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    for (int k = 0; k < 7; k++) begin
      if (k < 3) set_idling(31, 52);
      else if (k < 6) set_idling(52, 31);
      else set_idling(0, 0);
      wait_idle();
      program_cfg(sweep[k]);
      stamp = sweep[k].boot_hold_ms + $urandom_range(0, 2000);
      run_traffic(68);
    end
  endtask

  // Stall the result side long enough to back the block up into its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    wait_idle();
    program_cfg(make_cfg(1'b1, 1'b1, 4'd9, 16'd10, 16'd150, 16'd500, 16'd1200));
    stamp = 32'd20;
    rx_hold_cycles = 150;
    run_traffic(40);
    wait_idle();
    run_traffic(20);
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_config_sweep();
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      $error("%0d results never arrived", pending_outputs.size());
      fail_count++;
    end
    $display("Ran %0d samples under %0d register settings, %0d results checked.",
             samples_sent, settings_used, results_checked);
    $display("Touch releases none/short/long/superlong/longest: %0d/%0d/%0d/%0d/%0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
